// ===== hdl/deq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Holds the item layouts of the request and response channels, the action
// and status codes, and the default sizes of the element store.
// ----------------------------------------------------------------------------
package deq_pkg;

   // Default sizes of the element store.
   localparam int DEPTH_DEFAULT        = 16;
   localparam int ELEMENT_BITS_DEFAULT = 16;

   // Fixed widths of the item fields.
   localparam int ACTION_BITS = 3;
   localparam int VALUE_BITS  = 16;
   localparam int STATUS_BITS = 2;
   localparam int OCC_BITS    = 5;

   // Action codes.
   localparam logic [ACTION_BITS-1:0] ACT_PUSH_REAR  = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_PUSH_FRONT = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_POP_REAR   = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_DEL_FIRST  = 3'd4;
   localparam logic [ACTION_BITS-1:0] ACT_DEL_ALL    = 3'd5;

   // Status codes.
   localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd2;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

   // Request item.
   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [VALUE_BITS-1:0]  operand_value;
   } req_item_type;

   // Response item.
   typedef struct packed {
      logic [VALUE_BITS-1:0]  popped_value;
      logic [STATUS_BITS-1:0] status;
      logic [OCC_BITS-1:0]    occupancy;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== hdl/deq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram: generic simple dual-port RAM
// One write port and one read port per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hdl/deq_slot.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deq_slot: circular address unit
// Turns a position counted from the head into a store address, wrapping
// around the end of the store with one compare and subtract.
// ----------------------------------------------------------------------------
module deq_slot
   import deq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic [$clog2(DEPTH)-1:0]   base,
   input  wire logic [$clog2(DEPTH+1)-1:0] offset,
   output logic      [$clog2(DEPTH)-1:0]   slot
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] wrapped;

   // The sum stays below twice the depth, so one subtraction wraps it.
   always_comb begin
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(DEPTH)) begin
         wrapped = sum - SUM_W'(DEPTH);
      end else begin
         wrapped = sum;
      end
      slot = wrapped[PTR_W-1:0];
   end

endmodule
`default_nettype wire

// ===== hdl/deque_with_match_delete_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deque_with_match_delete_top: bounded double-ended queue with match delete
// Pushes and pops at both ends, plus deletion of the first or of every
// element equal to a key, over a circular element store in RAM.
// ----------------------------------------------------------------------------
// The block takes one request item at a time and returns one response item
// for it. A push passes the dispatch and done states before the next request
// is accepted; a pop also passes a wait state, since the element comes out of
// the registered RAM read port. A push into a full deque, a pop or match
// delete on an empty one, and an ignored action code pass dispatch and done
// only. A match delete makes one pass that streams every held element
// through the key compare, one element a cycle, and writes the survivors back
// in order behind the read pointer. The store needs no clearing after reset.
// A new request is accepted while a finished response still waits on the
// output register; the next response then waits in the done state for that
// one to drain. Requests are held off during reset.
// ----------------------------------------------------------------------------
module deque_with_match_delete_top
   import deq_pkg::*;
#(
   parameter int DEPTH        = DEPTH_DEFAULT,
   parameter int ELEMENT_BITS = ELEMENT_BITS_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_POP_WAIT = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_DONE     = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [ACTION_BITS-1:0]  act_ff, act_in;
   logic [ELEMENT_BITS-1:0] key_ff, key_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]        rd_left_ff, rd_left_in;
   logic [CNT_W-1:0]        kept_ff, kept_in;
   logic                    pend_ff, pend_in;
   logic                    found_ff, found_in;
   logic [VALUE_BITS-1:0]   popped_ff, popped_in;
   logic [STATUS_BITS-1:0]  status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_data_ff, rsp_data_in;

   logic                    ram_we;
   logic [PTR_W-1:0]        ram_wa;
   logic [ELEMENT_BITS-1:0] ram_wd;
   logic [PTR_W-1:0]        ram_ra;
   logic [ELEMENT_BITS-1:0] ram_rd;

   logic [CNT_W-1:0]        slot_off;
   logic [PTR_W-1:0]        slot_addr;

   logic                          full;
   logic                          empty;
   logic                          keep;
   logic                          rsp_load;
   logic [PTR_W-1:0]              head_inc;
   logic [PTR_W-1:0]              head_dec;
   logic [PTR_W-1:0]              rd_ptr_inc;
   logic [PTR_W-1:0]              wr_ptr_inc;
   logic [ELEMENT_BITS+VALUE_BITS-1:0] key_wide;
   logic [ELEMENT_BITS+VALUE_BITS-1:0] elem_wide;
   logic [CNT_W+OCC_BITS-1:0]          count_wide;

   // Step a store address forward with wrap at the end of the store.
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   // Element store.
   deq_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // Address unit for positions counted from the head.
   deq_slot #(
      .DEPTH (DEPTH)
   ) u_slot (
      .base   (head_ff),
      .offset (slot_off),
      .slot   (slot_addr)
   );

   // Width adaptation between the item fields and the stored elements.
   assign key_wide   = {{ELEMENT_BITS{1'b0}}, req_data.operand_value};
   assign elem_wide  = {{VALUE_BITS{1'b0}}, ram_rd};
   assign count_wide = {{OCC_BITS{1'b0}}, count_ff};

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign head_inc   = ptr_next(head_ff);
   assign head_dec   = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - 1'b1;
   assign rd_ptr_inc = ptr_next(rd_ptr_ff);
   assign wr_ptr_inc = ptr_next(wr_ptr_ff);

   // An element survives the scan unless it is the key, and once the first
   // match is gone a first-match delete keeps everything after it.
   assign keep = (ram_rd != key_ff) || ((act_ff == ACT_DEL_FIRST) && found_ff);

   // The response register takes a new item when it is empty or draining.
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      act_in     = act_ff;
      key_in     = key_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_left_in = rd_left_ff;
      kept_in    = kept_ff;
      pend_in    = pend_ff;
      found_in   = found_ff;
      popped_in  = popped_ff;
      status_in  = status_ff;
      ram_we     = 1'b0;
      ram_wa     = wr_ptr_ff;
      ram_wd     = key_ff;
      ram_ra     = rd_ptr_ff;
      slot_off   = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in   = req_data.action;
               key_in   = key_wide[ELEMENT_BITS-1:0];
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            popped_in = '0;
            status_in = ST_OK;
            state_in  = S_DONE;
            case (act_ff)
               ACT_PUSH_REAR: begin
                  if (full) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     ram_we   = 1'b1;
                     ram_wa   = slot_addr;
                     count_in = count_ff + 1'b1;
                  end
               end
               ACT_PUSH_FRONT: begin
                  if (full) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     ram_we   = 1'b1;
                     ram_wa   = head_dec;
                     head_in  = head_dec;
                     count_in = count_ff + 1'b1;
                  end
               end
               ACT_POP_FRONT: begin
                  if (empty) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     ram_ra   = head_ff;
                     head_in  = head_inc;
                     count_in = count_ff - 1'b1;
                     state_in = S_POP_WAIT;
                  end
               end
               ACT_POP_REAR: begin
                  if (empty) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     slot_off = count_ff - 1'b1;
                     ram_ra   = slot_addr;
                     count_in = count_ff - 1'b1;
                     state_in = S_POP_WAIT;
                  end
               end
               ACT_DEL_FIRST, ACT_DEL_ALL: begin
                  if (empty) begin
                     status_in = ST_NOT_FOUND;
                  end else begin
                     // Issue the read of the front element and start the pass.
                     ram_ra     = head_ff;
                     rd_ptr_in  = head_inc;
                     wr_ptr_in  = head_ff;
                     rd_left_in = count_ff - 1'b1;
                     kept_in    = '0;
                     pend_in    = 1'b1;
                     found_in   = 1'b0;
                     state_in   = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end

         S_POP_WAIT: begin
            popped_in = elem_wide[VALUE_BITS-1:0];
            state_in  = S_DONE;
         end

         S_SCAN: begin
            // Read side: one element a cycle until all have been fetched.
            if (rd_left_ff != '0) begin
               ram_ra     = rd_ptr_ff;
               rd_ptr_in  = rd_ptr_inc;
               rd_left_in = rd_left_ff - 1'b1;
               pend_in    = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            // Compare side: write survivors back behind the read pointer.
            if (pend_ff) begin
               if (keep) begin
                  ram_we    = 1'b1;
                  ram_wa    = wr_ptr_ff;
                  ram_wd    = ram_rd;
                  wr_ptr_in = wr_ptr_inc;
                  kept_in   = kept_ff + 1'b1;
               end else begin
                  found_in = 1'b1;
               end
            end else begin
               count_in  = kept_ff;
               status_in = (kept_ff == count_ff) ? ST_NOT_FOUND : ST_OK;
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.popped_value = popped_ff;
         rsp_data_in.status       = status_ff;
         rsp_data_in.occupancy    = count_wide[OCC_BITS-1:0];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      key_ff      <= key_in;
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      rd_left_ff  <= rd_left_in;
      kept_ff     <= kept_in;
      found_ff    <= found_in;
      popped_ff   <= popped_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
